[hw/rtl/bmh_pkg.sv]
// Shared types and constants for the bounded min-heap top-k block.
package bmh_pkg;

   // Heap geometry and field widths
   localparam int HEAP_DEPTH = 64;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int VAL_W      = 16;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register map: one register, word index taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(HEAP_DEPTH);

   // Request kinds carried on req_tuser
   localparam logic OPER_INSERT = 1'b0;
   localparam logic OPER_TAKE   = 1'b1;

   // Response packing
   localparam int RSP_BITS   = 2 * VAL_W + CNT_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TAKE_LD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LATCH,
      DP_BEGIN_INSERT,
      DP_BEGIN_REPLACE,
      DP_BEGIN_TAKE,
      DP_LOAD_LAST,
      DP_RD_PARENT,
      DP_RD_CHILD,
      DP_UP_MOVE,
      DP_DN_MOVE,
      DP_PUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;     // load the response register
   } cmd_type;

   typedef struct packed {
      logic is_take;       // latched request is a take
      logic full;          // count at or above effective capacity
      logic empty;         // count is zero
      logic gt_root;       // latched value strictly above the minimum
      logic pos_zero;      // hole sits at the root
      logic up_less;       // latched value below the parent just read
      logic move_down;     // a child just read is below the latched value
      logic out_full;      // response register holds an untaken transfer
   } status_type;

endpackage

[hw/rtl/bmh_ctrl.sv]
// Controller state machine for the bounded min-heap top-k block.
module bmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bmh_pkg::status_type status,
   output bmh_pkg::cmd_type    cmd
);
   import bmh_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.op     = DP_NONE;
      cmd.emit   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_LATCH;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_take) begin
               if (status.empty) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.op   = DP_BEGIN_TAKE;
                  state_in = ST_TAKE_LD;
               end
            end else if (!status.full) begin
               cmd.op   = DP_BEGIN_INSERT;
               state_in = ST_UP_RD;
            end else if (!status.empty && status.gt_root) begin
               cmd.op   = DP_BEGIN_REPLACE;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         // sift up: one parent read and compare per level
         ST_UP_RD: begin
            if (status.pos_zero) begin
               cmd.op   = DP_PUT;
               state_in = ST_DONE;
            end else begin
               cmd.op   = DP_RD_PARENT;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_less) begin
               cmd.op   = DP_UP_MOVE;
               state_in = ST_UP_RD;
            end else begin
               cmd.op   = DP_PUT;
               state_in = ST_DONE;
            end
         end
         ST_TAKE_LD: begin
            cmd.op   = DP_LOAD_LAST;
            state_in = ST_DN_RD;
         end
         // sift down: both children read together, then compare
         ST_DN_RD: begin
            cmd.op   = DP_RD_CHILD;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (status.move_down) begin
               cmd.op   = DP_DN_MOVE;
               state_in = ST_DN_RD;
            end else begin
               cmd.op   = DP_PUT;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_full) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/bmh_datapath.sv]
// Heap memory, sift registers and response register of the min-heap block.
module bmh_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bmh_pkg::cmd_type                  cmd,
   output bmh_pkg::status_type               status,
   input  logic [bmh_pkg::CNT_W-1:0]         capacity,
   input  logic                              req_operation,
   input  logic signed [bmh_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bmh_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bmh_pkg::*;

   // Heap storage, two registered read ports, one write port
   logic signed [VAL_W-1:0] mem [HEAP_DEPTH];
   logic signed [VAL_W-1:0] rd_a_ff;
   logic signed [VAL_W-1:0] rd_b_ff;
   logic [ADDR_W-1:0]       addr_a;
   logic [ADDR_W-1:0]       addr_b;
   logic                    wr_en;
   logic signed [VAL_W-1:0] wr_data;

   // Sift state
   logic [ADDR_W-1:0]       pos_ff,   pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] val_ff,   val_in;
   logic                    op_ff,    op_in;
   logic signed [VAL_W-1:0] taken_ff, taken_in;
   logic                    took_ff,  took_in;
   logic signed [VAL_W-1:0] root_ff;

   // Response register
   logic                    out_valid_ff;
   logic [RSP_DATA_W-1:0]   out_data_ff;

   // Index arithmetic
   logic [ADDR_W-1:0]       pos_minus;
   logic [ADDR_W-1:0]       parent;
   logic [CNT_W:0]          l_idx;
   logic [CNT_W:0]          r_idx;
   logic [CNT_W-1:0]        last_idx;
   logic [CNT_W-1:0]        eff_cap;
   logic                    has_l;
   logic                    has_r;
   logic                    l_less;
   logic                    r_less;
   logic signed [VAL_W-1:0] cand;
   logic signed [VAL_W-1:0] best_val;
   logic [ADDR_W-1:0]       best_pos;
   logic                    min_valid;
   logic signed [VAL_W-1:0] min_value;

   assign pos_minus = pos_ff - ADDR_W'(1);
   assign parent    = {1'b0, pos_minus[ADDR_W-1:1]};
   assign l_idx     = {1'b0, pos_ff, 1'b1};
   assign r_idx     = l_idx + (CNT_W+1)'(1);
   assign last_idx  = count_ff - CNT_W'(1);
   assign has_l     = l_idx < {1'b0, count_ff};
   assign has_r     = r_idx < {1'b0, count_ff};

   // Capacity register saturated to 1..HEAP_DEPTH
   always_comb begin
      if (capacity == '0) begin
         eff_cap = CNT_W'(1);
      end else if (capacity > CNT_W'(HEAP_DEPTH)) begin
         eff_cap = CNT_W'(HEAP_DEPTH);
      end else begin
         eff_cap = capacity;
      end
   end

   // Smaller child below the held value, left wins ties
   assign l_less   = has_l && (rd_a_ff < val_ff);
   assign cand     = l_less ? rd_a_ff : val_ff;
   assign r_less   = has_r && (rd_b_ff < cand);
   assign best_val = r_less ? rd_b_ff : rd_a_ff;
   assign best_pos = r_less ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

   assign min_valid = count_ff != '0;
   assign min_value = min_valid ? root_ff : '0;

   // Status to the controller
   always_comb begin
      status.is_take   = op_ff == OPER_TAKE;
      status.full      = count_ff >= eff_cap;
      status.empty     = count_ff == '0;
      status.gt_root   = val_ff > root_ff;
      status.pos_zero  = pos_ff == '0;
      status.up_less   = val_ff < rd_a_ff;
      status.move_down = l_less || r_less;
      status.out_full  = out_valid_ff && !rsp_tready;
   end

   // Operation decode
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      val_in   = val_ff;
      op_in    = op_ff;
      taken_in = taken_ff;
      took_in  = took_ff;
      addr_a   = parent;
      addr_b   = r_idx[ADDR_W-1:0];
      wr_en    = 1'b0;
      wr_data  = val_ff;
      unique case (cmd.op)
         DP_LATCH: begin
            op_in    = req_operation;
            val_in   = req_value;
            taken_in = '0;
            took_in  = 1'b0;
         end
         DP_BEGIN_INSERT: begin
            pos_in   = count_ff[ADDR_W-1:0];
            count_in = count_ff + CNT_W'(1);
         end
         DP_BEGIN_REPLACE: begin
            pos_in = '0;
         end
         DP_BEGIN_TAKE: begin
            addr_a   = last_idx[ADDR_W-1:0];
            taken_in = root_ff;
            took_in  = 1'b1;
            count_in = last_idx;
            pos_in   = '0;
         end
         DP_LOAD_LAST: begin
            val_in = rd_a_ff;
         end
         DP_RD_PARENT: begin
            addr_a = parent;
         end
         DP_RD_CHILD: begin
            addr_a = l_idx[ADDR_W-1:0];
            addr_b = r_idx[ADDR_W-1:0];
         end
         DP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_a_ff;
            pos_in  = parent;
         end
         DP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = best_val;
            pos_in  = best_pos;
         end
         DP_PUT: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Payload registers; the root copy follows every write to entry zero
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      op_ff    <= op_in;
      taken_ff <= taken_in;
      took_ff  <= took_in;
      if (wr_en && pos_ff == '0) begin
         root_ff <= wr_data;
      end
      if (cmd.emit) begin
         out_data_ff <= RSP_DATA_W'({min_valid, min_value, count_ff, took_ff, taken_ff});
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[hw/rtl/bounded_min_heap_top_k_top.sv]
// Top level of the bounded min-heap top-k block: ports and capacity register.
//
//  channel   | role          | payload
//  ----------+---------------+-------------------------------------------------
//  req_*     | stream in     | tuser: operation; tdata: value
//  rsp_*     | stream out    | tdata: taken_value, took_valid, count, min_value,
//            |               |        min_valid
//  csr_*     | APB register  | capacity at byte address 0
//
// One request at a time. An insert sifts up until it reaches the root or a parent that
// is not larger; a replace sifts down from the root of a full heap, and a take loads
// the last entry and sifts it down; a dropped insert or an empty take goes straight to
// the result. A level is one memory read and one compare. Synchronous reset empties
// the heap but does not clear the memory. A waiting result lets the next request in; a
// stalled rsp side holds the block at its end.
module bounded_min_heap_top_k_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // [0] operation
   input  logic [15:0]                       req_tdata,   // [15:0] value
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] taken_value, [16] took_valid, [23:17] count, [39:24] min_value,
   // [40] min_valid, [47:41] zero
   output logic [bmh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bmh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bmh_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bmh_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bmh_pkg::*;

   logic [CNT_W-1:0] capacity_ff;
   logic             csr_write;
   status_type       status;
   cmd_type          cmd;

   // Capacity register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write && csr_paddr[2] == REG_CAPACITY) begin
         capacity_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   bmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmh_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .capacity      (capacity_ff),
      .req_operation (req_tuser),
      .req_value     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

[hw/rtl/bmh_checker.sv]
// Port-level checks for the bounded min-heap top-k block and their binding.
module bmh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic [15:0]                       req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bmh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [bmh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input logic [bmh_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input logic [bmh_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input logic                              csr_pready
);
   import bmh_pkg::*;

   // A stalled result transfer holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One request at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // min_valid tracks a nonzero count
   a_min_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[40] == (rsp_tdata[23:17] != '0)))
      else $error("min_valid disagrees with count");

   // An unsuccessful or absent take reports zero
   a_taken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[15:0] == '0)
      else $error("taken_value nonzero without a take");

   // Count never exceeds the heap depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:17] <= CNT_W'(HEAP_DEPTH))
      else $error("count beyond heap depth");

endmodule

bind bounded_min_heap_top_k_top bmh_checker u_bmh_checker (.*);
